>>> sv/battery_drain_average_time_left_macros.svh
// Assertion macros for the runtime estimator.
`ifndef BATTERY_DRAIN_AVERAGE_TIME_LEFT_MACROS_SVH
`define BATTERY_DRAIN_AVERAGE_TIME_LEFT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDATL_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed in battery runtime estimator");

// The consequent must hold in the cycle after the antecedent.
`define BDATL_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed in battery runtime estimator");

`endif

>>> sv/bdatl_pkg.sv
package bdatl_pkg;

    // Window geometry and datapath widths.
    localparam int WINDOW   = 60;
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int COUNT_W  = $clog2(WINDOW + 1);
    localparam int DATA_W   = 32;
    localparam int SUM_W    = DATA_W + SLOT_W;
    localparam int STEP_W   = 6;
    localparam int HOURS_W  = 7;
    localparam int MINS_W   = 6;

    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [HOURS_W-1:0] HOURS_MAX = 7'd127;

    // Division lengths: each is the number of quotient bits needed.
    localparam logic [STEP_W-1:0] AVG_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] HRS_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] MIN_STEPS = 6'd6;

    // Charge state codes.
    localparam logic [1:0] CS_UNKNOWN     = 2'd0;
    localparam logic [1:0] CS_DISCHARGING = 2'd1;
    localparam logic [1:0] CS_CHARGING    = 2'd2;
    localparam logic [1:0] CS_RESERVED    = 2'd3;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } ring_ctl_t;

endpackage

>>> sv/bdatl_ring.sv
module bdatl_ring (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bdatl_pkg::ring_ctl_t          ctl,
    input  logic [bdatl_pkg::SLOT_W-1:0]  rd_addr,
    input  logic [bdatl_pkg::SLOT_W-1:0]  wr_addr,
    input  logic [bdatl_pkg::DATA_W-1:0]  wr_data,
    output logic [bdatl_pkg::DATA_W-1:0]  rd_data,
    output logic                          rd_valid
);

    logic [bdatl_pkg::DATA_W-1:0] ring_mem [bdatl_pkg::WINDOW];
    logic [bdatl_pkg::WINDOW-1:0] valid_reg;
    logic [bdatl_pkg::DATA_W-1:0] rd_data_reg;
    logic                         rd_valid_reg;

    // Sample store with a registered read port.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Per-slot valid bits; a clear empties the whole window at once, and a read
    // issued together with a clear sees an empty slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.clear) begin
                valid_reg <= '0;
            end else if (ctl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr] && !ctl.clear;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> sv/bdatl_div.sv
module bdatl_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bdatl_pkg::div_ctl_t           ctl,
    input  logic [bdatl_pkg::SUM_W-1:0]   dividend,
    input  logic [bdatl_pkg::DATA_W-1:0]  divisor,
    output bdatl_pkg::div_stat_t          stat,
    output logic [bdatl_pkg::DATA_W-1:0]  quotient,
    output logic [bdatl_pkg::DATA_W-1:0]  remainder
);

    logic [bdatl_pkg::DATA_W-1:0] rem_reg;
    logic [bdatl_pkg::SUM_W-1:0]  quo_reg;
    logic [bdatl_pkg::DATA_W-1:0] divisor_reg;
    logic [bdatl_pkg::STEP_W-1:0] cnt_reg;
    logic                         done_reg;

    logic [bdatl_pkg::DATA_W:0]   trial;
    logic [bdatl_pkg::DATA_W:0]   diff;
    logic                         fits;
    logic [bdatl_pkg::DATA_W-1:0] rem_step;
    logic [6:0]                   top_shift;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial     = {rem_reg, quo_reg[bdatl_pkg::SUM_W-1]};
        diff      = trial - {1'b0, divisor_reg};
        fits      = trial >= {1'b0, divisor_reg};
        rem_step  = fits ? diff[bdatl_pkg::DATA_W-1:0] : trial[bdatl_pkg::DATA_W-1:0];
        top_shift = 7'(bdatl_pkg::SUM_W) - {1'b0, ctl.steps};
    end

    // The caller guarantees that the quotient fits in the requested number of
    // steps, so the bits above them preload the partial remainder.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg     <= bdatl_pkg::DATA_W'(dividend >> ctl.steps);
            quo_reg     <= dividend << top_shift;
            divisor_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[bdatl_pkg::SUM_W-2:0], fits};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == bdatl_pkg::STEP_W'(1)) && !ctl.start;
            if (ctl.start) begin
                cnt_reg <= ctl.steps;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - bdatl_pkg::STEP_W'(1);
            end
        end
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;
    assign quotient  = quo_reg[bdatl_pkg::DATA_W-1:0];
    assign remainder = rem_reg;

endmodule

>>> sv/battery_drain_average_time_left.sv
// Each accepted item runs the average division if it carries a drain sample, then the hours
// and minutes divisions unless the average is zero, in which case the time is reported as zero.
// All three run on the one shared radix-2 divider: 32 steps for the average,
// 32 for the hours and 6 for the minutes. One item is worked on at a time.
// The next item is accepted the cycle after the result register is loaded, and a result
// that waits on m_tready holds it back. Synchronous active-low reset empties the window
// and clears the average and state.
`include "battery_drain_average_time_left_macros.svh"

module battery_drain_average_time_left (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // charge_state[1:0], drain_sample[33:2], charge_left[65:34], zero padding
    input  logic [71:0] s_tdata,
    // sample_present
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // drain_average[31:0], hours_left[38:32], minutes_left[44:39], zero padding
    output logic [47:0] m_tdata,
    // average_changed[0], state_changed[1]
    output logic [1:0]  m_tuser
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_UPD      = 9'b000000010,
        ST_AVG_GO   = 9'b000000100,
        ST_AVG_WAIT = 9'b000001000,
        ST_CHK      = 9'b000010000,
        ST_HRS_WAIT = 9'b000100000,
        ST_MIN_GO   = 9'b001000000,
        ST_MIN_WAIT = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                          stored_cs_reg;
    logic [bdatl_pkg::SLOT_W-1:0]        slot_reg;
    logic [bdatl_pkg::SUM_W-1:0]         sum_reg;
    logic [bdatl_pkg::COUNT_W-1:0]       count_reg;
    logic [bdatl_pkg::DATA_W-1:0]        avg_reg;
    logic [bdatl_pkg::DATA_W-1:0]        avg_before_reg;
    logic                                st_chg_reg;
    logic                                present_reg;
    logic [bdatl_pkg::DATA_W-1:0]        sample_reg;
    logic [bdatl_pkg::DATA_W-1:0]        cap_reg;
    logic [bdatl_pkg::DATA_W-1:0]        rem_reg;
    logic [bdatl_pkg::HOURS_W-1:0]       hours_reg;
    logic [bdatl_pkg::MINS_W-1:0]        minutes_reg;
    logic                                m_tvalid_reg;
    logic [47:0]                         m_tdata_reg;
    logic [1:0]                          m_tuser_reg;

    logic                                accept;
    logic [1:0]                          cs_norm;
    logic                                cs_changed;
    logic [bdatl_pkg::SUM_W-1:0]         old_sample;
    logic [bdatl_pkg::SUM_W-1:0]         sum_upd;
    logic [bdatl_pkg::SUM_W-1:0]         rem_times_60;

    bdatl_pkg::ring_ctl_t                ring_ctl;
    logic [bdatl_pkg::SLOT_W-1:0]        ring_rd_addr;
    logic [bdatl_pkg::DATA_W-1:0]        ring_rd_data;
    logic                                ring_rd_valid;

    bdatl_pkg::div_ctl_t                 div_ctl;
    bdatl_pkg::div_stat_t                div_stat;
    logic [bdatl_pkg::SUM_W-1:0]         div_dividend;
    logic [bdatl_pkg::DATA_W-1:0]        div_divisor;
    logic [bdatl_pkg::DATA_W-1:0]        div_quotient;
    logic [bdatl_pkg::DATA_W-1:0]        div_remainder;

    // Input decode: the reserved charge code counts as unknown.
    always_comb begin
        accept     = s_tvalid && s_tready;
        cs_norm    = (s_tdata[1:0] == bdatl_pkg::CS_RESERVED) ? bdatl_pkg::CS_UNKNOWN
                                                              : s_tdata[1:0];
        cs_changed = cs_norm != stored_cs_reg;
    end

    // Window sum update: drop the overwritten sample if that slot was in use.
    always_comb begin
        old_sample   = ring_rd_valid ? bdatl_pkg::SUM_W'(ring_rd_data) : '0;
        sum_upd      = sum_reg - old_sample + bdatl_pkg::SUM_W'(sample_reg);
        rem_times_60 = (bdatl_pkg::SUM_W'(rem_reg) << 6) - (bdatl_pkg::SUM_W'(rem_reg) << 2);
    end

    // Ring control: the old slot is read on acceptance and rewritten in the update when a sample is present.
    always_comb begin
        ring_ctl.clear = accept && cs_changed;
        ring_ctl.rd_en = accept;
        ring_ctl.wr_en = (state_reg == ST_UPD) && present_reg;
        ring_rd_addr   = cs_changed ? '0 : slot_reg;
    end

    // Divider operand selection for the three divisions.
    always_comb begin
        div_ctl.start = 1'b0;
        div_ctl.steps = bdatl_pkg::AVG_STEPS;
        div_dividend  = sum_reg;
        div_divisor   = bdatl_pkg::DATA_W'(count_reg);
        unique case (state_reg)
            ST_AVG_GO: begin
                div_ctl.start = 1'b1;
            end
            ST_CHK: begin
                div_ctl.start = avg_reg != '0;
                div_ctl.steps = bdatl_pkg::HRS_STEPS;
                div_dividend  = bdatl_pkg::SUM_W'(cap_reg);
                div_divisor   = avg_reg;
            end
            ST_MIN_GO: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = bdatl_pkg::MIN_STEPS;
                div_dividend  = rem_times_60;
                div_divisor   = avg_reg;
            end
            default: begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_UPD;
            ST_UPD:      state_next = present_reg ? ST_AVG_GO : ST_CHK;
            ST_AVG_GO:   state_next = ST_AVG_WAIT;
            ST_AVG_WAIT: if (div_stat.done) state_next = ST_CHK;
            ST_CHK:      state_next = (avg_reg != '0) ? ST_HRS_WAIT : ST_DONE;
            ST_HRS_WAIT: if (div_stat.done) state_next = ST_MIN_GO;
            ST_MIN_GO:   state_next = ST_MIN_WAIT;
            ST_MIN_WAIT: if (div_stat.done) state_next = ST_DONE;
            ST_DONE:     if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control and window state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stored_cs_reg <= bdatl_pkg::CS_UNKNOWN;
            slot_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && cs_changed) begin
                stored_cs_reg <= cs_norm;
                slot_reg      <= '0;
                sum_reg       <= '0;
                count_reg     <= '0;
            end
            if ((state_reg == ST_UPD) && present_reg) begin
                sum_reg  <= sum_upd;
                slot_reg <= (slot_reg == bdatl_pkg::LAST_SLOT) ? '0
                                                               : slot_reg + 1'b1;
                if (!ring_rd_valid) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if ((state_reg == ST_AVG_WAIT) && div_stat.done) begin
                avg_reg <= div_quotient;
            end
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item payload and intermediate results.
    always_ff @(posedge aclk) begin
        if (accept) begin
            present_reg    <= s_tuser;
            sample_reg     <= s_tdata[33:2];
            cap_reg        <= s_tdata[65:34];
            st_chg_reg     <= cs_changed;
            avg_before_reg <= avg_reg;
        end
        if (state_reg == ST_CHK) begin
            hours_reg   <= '0;
            minutes_reg <= '0;
        end
        if ((state_reg == ST_HRS_WAIT) && div_stat.done) begin
            hours_reg <= (div_quotient > bdatl_pkg::DATA_W'(bdatl_pkg::HOURS_MAX))
                         ? bdatl_pkg::HOURS_MAX : div_quotient[bdatl_pkg::HOURS_W-1:0];
            rem_reg   <= div_remainder;
        end
        if ((state_reg == ST_MIN_WAIT) && div_stat.done) begin
            minutes_reg <= div_quotient[bdatl_pkg::MINS_W-1:0];
        end
        if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {3'b000, minutes_reg, hours_reg, avg_reg};
            m_tuser_reg <= {st_chg_reg, avg_reg != avg_before_reg};
        end
    end

    bdatl_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ring_ctl),
        .rd_addr  (ring_rd_addr),
        .wr_addr  (slot_reg),
        .wr_data  (sample_reg),
        .rd_data  (ring_rd_data),
        .rd_valid (ring_rd_valid)
    );

    bdatl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks on the sequencer, the window bookkeeping and the result fields.
    `BDATL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    `BDATL_ASSERT_NOW(a_count_in_window, aclk, aresetn, 1'b1,
                      count_reg <= bdatl_pkg::COUNT_W'(bdatl_pkg::WINDOW))
    `BDATL_ASSERT_NOW(a_div_when_waiting, aclk, aresetn, div_stat.busy || div_stat.done,
                      (state_reg == ST_AVG_WAIT) || (state_reg == ST_HRS_WAIT) ||
                      (state_reg == ST_MIN_WAIT))
    `BDATL_ASSERT_NOW(a_zero_avg_no_time, aclk, aresetn,
                      m_tvalid && (m_tdata[31:0] == '0), m_tdata[44:32] == '0)
    `BDATL_ASSERT_NOW(a_minutes_range, aclk, aresetn, m_tvalid, m_tdata[44:39] < 6'd60)

endmodule
